>>> rtl/sgbp_pkg.sv
package sgbp_pkg;

  // Default plan limits
  localparam int MAX_BURST_BYTES_DEF = 4096;
  localparam int BEAT_SHIFT_DEF      = 4;
  localparam int MAX_PAGE_BYTES_DEF  = 4096;

  // Queue depths between front, back and result side
  localparam int QUEUE_DEPTH = 2;

  // Field widths
  localparam int PADDR_W     = 48;
  localparam int PBYTES_W    = 14;
  localparam int PSIZE_W     = 13;   // a page that passed the size check fits here
  localparam int WADDR_W     = 49;
  localparam int BAL_W       = 18;
  localparam int WIDTH_W     = 14;
  localparam int STRIDE_W    = 16;
  localparam int COUNT_W     = 12;
  localparam int BURST_W     = 13;
  localparam int BEAT_ADDR_W = 44;
  localparam int BEATS_W     = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd2;

  // Reset values and floors
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 14'd1920;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 16'd1920;
  localparam logic [COUNT_W-1:0]  COUNT_RST  = 12'd1080;
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = 14'd256;
  localparam logic [STRIDE_W-1:0] STRIDE_MIN = 16'd256;

  // Classified page descriptor, front to back
  typedef struct packed {
    logic [PADDR_W-1:0] addr;
    logic [PSIZE_W-1:0] bytes;
    logic               first;
    logic               oversize;
  } page_t;

  // One planned result
  typedef struct packed {
    logic [BEAT_ADDR_W-1:0] beat_addr;
    logic [BEATS_W-1:0]     beats;
    logic                   line_done;
    logic                   frame_done;
    logic                   page_error;
    logic                   last;
  } result_t;

  // Effective frame geometry
  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [STRIDE_W-1:0] gap;
    logic [COUNT_W-1:0]  count;
  } cfg_t;

endpackage

>>> rtl/sgbp_fifo.sv
module sgbp_fifo import sgbp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> rtl/sgbp_front.sv
module sgbp_front import sgbp_pkg::*; #(
  parameter int MAX_PAGE_BYTES = MAX_PAGE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [PADDR_W-1:0]  page_address,
  input  logic [PBYTES_W-1:0] page_bytes,
  input  logic                first_of_frame,
  input  logic                q_pop,
  output logic                q_empty,
  output page_t               q_data
);

  page_t entry;

  // size check up front; an oversized page is flagged and its size truncated
  always_comb begin
    entry.addr     = page_address;
    entry.bytes    = page_bytes[PSIZE_W-1:0];
    entry.first    = first_of_frame;
    entry.oversize = (page_bytes > PBYTES_W'(MAX_PAGE_BYTES));
  end

  sgbp_fifo #(
    .WIDTH ($bits(page_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_page_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .din   (entry),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_data)
  );

endmodule

>>> rtl/sgbp_back.sv
module sgbp_back import sgbp_pkg::*; #(
  parameter int MAX_BURST_BYTES = MAX_BURST_BYTES_DEF,
  parameter int BEAT_SHIFT      = BEAT_SHIFT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_empty,
  output logic    q_pop,
  input  page_t   q_data,
  input  logic    out_full,
  output logic    out_push,
  output result_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_BURST
  } state_t;

  state_t                   state, state_next;
  page_t                    item, item_next;
  logic [WADDR_W-1:0]       waddr, waddr_next;
  logic signed [BAL_W-1:0]  bal, bal_next;
  logic [WIDTH_W-1:0]       lbl, lbl_next;
  logic [COUNT_W-1:0]       lines, lines_next;
  logic                     active, active_next;

  logic                     act0;
  logic signed [BAL_W-1:0]  bal0;
  logic [BAL_W-1:0]         skip;
  logic signed [BAL_W-1:0]  bal_sum;
  logic [BURST_W-1:0]       burst;
  logic [WIDTH_W-1:0]       lbl_after;
  logic                     line_end;
  logic [COUNT_W-1:0]       lines_inc;
  logic                     fdone;
  logic signed [BAL_W-1:0]  bal_after;
  logic                     last;
  logic [WADDR_W-1:0]       wa_shift;
  logic [BURST_W-1:0]       beats_shift;
  logic [STRIDE_W-1:0]      gap_step;

  always_comb begin
    // setup view: frame restart applied ahead of the page
    act0    = item.first ? 1'b1 : active;
    bal0    = item.first ? '0 : bal;
    skip    = -bal0;
    bal_sum = bal0 + $signed({{(BAL_W-PSIZE_W){1'b0}}, item.bytes});

    // burst view: bal is positive and at most one page here
    burst = bal[BURST_W-1:0];
    if (burst > BURST_W'(MAX_BURST_BYTES)) begin
      burst = BURST_W'(MAX_BURST_BYTES);
    end
    if ({1'b0, burst} > lbl) begin
      burst = lbl[BURST_W-1:0];
    end
    lbl_after = lbl - {1'b0, burst};
    line_end  = (lbl_after == '0);
    lines_inc = (lines != '1) ? lines + 1'b1 : lines;
    fdone     = line_end && (lines_inc >= cfg.count);
    gap_step  = line_end ? cfg.gap : '0;
    bal_after = bal - $signed({{(BAL_W-BURST_W){1'b0}}, burst})
                    - $signed({{(BAL_W-STRIDE_W){1'b0}}, gap_step});
    last      = fdone || !(bal_after > 0);

    wa_shift    = waddr >> BEAT_SHIFT;
    beats_shift = burst >> BEAT_SHIFT;

    state_next  = state;
    item_next   = item;
    waddr_next  = waddr;
    bal_next    = bal;
    lbl_next    = lbl;
    lines_next  = lines;
    active_next = active;
    q_pop       = 1'b0;
    out_push    = 1'b0;
    out_data    = '0;

    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          item_next  = q_data;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        // hold the whole step until a result slot is free
        if (!out_full) begin
          if (item.first) begin
            lines_next  = '0;
            bal_next    = '0;
            lbl_next    = cfg.width;
            active_next = 1'b1;
          end
          if (!act0) begin
            state_next = ST_IDLE;
          end else if (item.oversize) begin
            out_push            = 1'b1;
            out_data.page_error = 1'b1;
            out_data.last       = 1'b1;
            state_next          = ST_IDLE;
          end else begin
            waddr_next = WADDR_W'(item.addr) + WADDR_W'(skip);
            bal_next   = bal_sum;
            state_next = (bal_sum > 0) ? ST_BURST : ST_IDLE;
          end
        end
      end
      ST_BURST: begin
        if (!out_full) begin
          out_push            = 1'b1;
          out_data.beat_addr  = wa_shift[BEAT_ADDR_W-1:0];
          out_data.beats      = beats_shift[BEATS_W-1:0];
          out_data.line_done  = line_end;
          out_data.frame_done = fdone;
          out_data.last       = last;
          bal_next   = bal_after;
          waddr_next = waddr + WADDR_W'(burst) + WADDR_W'(gap_step);
          if (line_end) begin
            lines_next = lines_inc;
            if (fdone) begin
              active_next = 1'b0;
            end else begin
              lbl_next = cfg.width;
            end
          end else begin
            lbl_next = lbl_after;
          end
          if (last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    item <= item_next;
    if (rst) begin
      state  <= ST_IDLE;
      waddr  <= '0;
      bal    <= '0;
      lbl    <= WIDTH_RST;
      lines  <= '0;
      active <= 1'b0;
    end else begin
      state  <= state_next;
      waddr  <= waddr_next;
      bal    <= bal_next;
      lbl    <= lbl_next;
      lines  <= lines_next;
      active <= active_next;
    end
  end

endmodule

>>> rtl/scatter_gather_burst_planner_unit.sv
// Scatter-gather burst planner.
// Page channel: push/full queue. A page descriptor (address, size,
// first_of_frame) transfers at a clock edge with push high and full low.
// Result channel: empty/pop queue. While empty is low the oldest burst sits
// on the result ports; it transfers at an edge with pop high.
// Config channel: cfg_valid/cfg_ready, always ready; index 0 line width,
// 1 line stride, 2 line count. Write only while the block is idle.
// With the planner idle, a page passes the page queue and the sequencer's
// idle and setup states; bursts go from the burst state, and an oversized
// page's error result from setup, into the result queue. One page is planned
// at a time, one burst per cycle while the result queue has room; pages with
// no burst (gap, empty, inactive frame, oversized) leave after setup.
// A two-entry page queue decouples intake from planning, and a two-entry
// result queue lets intake and planning keep going while the receiver
// stalls; planning halts once that queue is full, then intake fills up.
// Reset (synchronous, rst high) empties both queues, ends any frame and
// loads width 1920, stride 1920, count 1080.
module scatter_gather_burst_planner_unit import sgbp_pkg::*; #(
  parameter int MAX_BURST_BYTES = MAX_BURST_BYTES_DEF,
  parameter int BEAT_SHIFT      = BEAT_SHIFT_DEF,
  parameter int MAX_PAGE_BYTES  = MAX_PAGE_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // page descriptors
  input  logic                   push,
  output logic                   full,
  input  logic [PADDR_W-1:0]     page_address,
  input  logic [PBYTES_W-1:0]    page_bytes,
  input  logic                   first_of_frame,
  // planned bursts
  output logic                   empty,
  input  logic                   pop,
  output logic [BEAT_ADDR_W-1:0] burst_beat_address,
  output logic [BEATS_W-1:0]     burst_beats,
  output logic                   line_done,
  output logic                   frame_done,
  output logic                   page_error,
  output logic                   last_of_run,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [WIDTH_W-1:0]  line_width;
  logic [STRIDE_W-1:0] line_stride;
  logic [COUNT_W-1:0]  line_cnt;

  logic [WIDTH_W-1:0]  width_eff;
  logic [STRIDE_W-1:0] stride_eff;
  cfg_t                cfg;

  logic    q_empty;
  logic    q_pop;
  page_t   q_data;
  logic    res_full;
  logic    res_push;
  result_t res_in;
  result_t res_out;

  assign cfg_ready = 1'b1;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width  <= WIDTH_RST;
      line_stride <= STRIDE_RST;
      line_cnt    <= COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:  line_width  <= cfg_data[WIDTH_W-1:0];
        REG_LINE_STRIDE: line_stride <= cfg_data[STRIDE_W-1:0];
        REG_LINE_COUNT:  line_cnt    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range settings; stride below width means no gap
  always_comb begin
    width_eff  = (line_width < WIDTH_MIN) ? WIDTH_MIN : line_width;
    stride_eff = (line_stride < STRIDE_MIN) ? STRIDE_MIN : line_stride;
    cfg.width  = width_eff;
    cfg.gap    = (stride_eff > STRIDE_W'(width_eff)) ?
                 stride_eff - STRIDE_W'(width_eff) : '0;
    cfg.count  = (line_cnt == '0) ? COUNT_W'(1) : line_cnt;
  end

  sgbp_front #(
    .MAX_PAGE_BYTES (MAX_PAGE_BYTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .page_address   (page_address),
    .page_bytes     (page_bytes),
    .first_of_frame (first_of_frame),
    .q_pop          (q_pop),
    .q_empty        (q_empty),
    .q_data         (q_data)
  );

  sgbp_back #(
    .MAX_BURST_BYTES (MAX_BURST_BYTES),
    .BEAT_SHIFT      (BEAT_SHIFT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_data   (q_data),
    .out_full (res_full),
    .out_push (res_push),
    .out_data (res_in)
  );

  // result queue decouples planning from the receiver
  sgbp_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (res_in),
    .pop   (pop),
    .empty (empty),
    .dout  (res_out)
  );

  assign burst_beat_address = res_out.beat_addr;
  assign burst_beats        = res_out.beats;
  assign line_done          = res_out.line_done;
  assign frame_done         = res_out.frame_done;
  assign page_error         = res_out.page_error;
  assign last_of_run        = res_out.last;

endmodule

>>> test/scatter_gather_burst_planner_unit_tb.sv
module scatter_gather_burst_planner_unit_tb;
  import sgbp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Plan limits as the block is built (package defaults)
  localparam int MAX_BURST = MAX_BURST_BYTES_DEF;
  localparam int BEAT_SH   = BEAT_SHIFT_DEF;
  localparam logic [PBYTES_W-1:0] MAX_PAGE = PBYTES_W'(MAX_PAGE_BYTES_DEF);
  // Cap on the bursts planned for one page
  localparam int BURSTS_PER_PAGE = 34;
  // Index with no register behind it; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // Cycles the page queue and sequencer may still be busy on pages that
  // produce nothing, once the last expected burst is out
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 600000;

  // One expected result transfer
  typedef struct {
    logic [BEAT_ADDR_W-1:0] beat_addr;
    logic [BEATS_W-1:0]     beats;
    logic                   line_end;
    logic                   frame_end;
    logic                   oversize;
    logic                   last;
  } burst_exp_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic [PADDR_W-1:0]     page_address = '0;
  logic [PBYTES_W-1:0]    page_bytes = '0;
  logic                   first_of_frame = 1'b0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [BEAT_ADDR_W-1:0] burst_beat_address;
  logic [BEATS_W-1:0]     burst_beats;
  logic                   line_done;
  logic                   frame_done;
  logic                   page_error;
  logic                   last_of_run;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  scatter_gather_burst_planner_unit dut (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .page_address       (page_address),
    .page_bytes         (page_bytes),
    .first_of_frame     (first_of_frame),
    .empty              (empty),
    .pop                (pop),
    .burst_beat_address (burst_beat_address),
    .burst_beats        (burst_beats),
    .line_done          (line_done),
    .frame_done         (frame_done),
    .page_error         (page_error),
    .last_of_run        (last_of_run),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Planner shadow: geometry registers and frame state
  // ---------------------------------------------------------------------
  int unsigned geo_width  = 1920;
  int unsigned geo_stride = 1920;
  int unsigned geo_count  = 1080;

  logic [WADDR_W-1:0] wr_addr = '0;
  int                 balance = 0;     // goes negative across a stride gap
  int unsigned        line_left = 1920;
  int unsigned        lines_cnt = 0;
  bit                 frame_on = 1'b0;
  bit                 page_ignored;

  burst_exp_t planned_bursts[$];

  // Bookkeeping
  int mismatches = 0;
  int results_checked = 0;
  int pages_sent = 0;
  int pages_planned = 0;
  int cfg_writes = 0;
  int cycles = 0;

  // Idle draws: 0 means that side runs flat out
  int tx_max = 7;
  int rx_max = 7;
  int pop_wait = 0;

  // Work out every burst one accepted page causes and queue them
  task automatic plan_page(input logic [PADDR_W-1:0] addr, input logic [PBYTES_W-1:0] nbytes,
                           input logic sof);
    int unsigned width, stride, count, gap, burst;
    logic [31:0] skip;
    burst_exp_t  e;
    burst_exp_t  run[$];
    int          n;
    // registers below their floor count as the floor
    width  = (geo_width < 256) ? 256 : geo_width;
    stride = (geo_stride < 256) ? 256 : geo_stride;
    count  = (geo_count == 0) ? 1 : geo_count;
    // stride below width means back-to-back lines
    gap    = (stride > width) ? stride - width : 0;
    // restart applies even to a page rejected below
    if (sof) begin
      lines_cnt = 0;
      balance   = 0;
      line_left = width;
      frame_on  = 1'b1;
    end
    page_ignored = !frame_on;
    if (!frame_on) return;
    e = '{default: '0};
    if (nbytes > MAX_PAGE) begin
      // oversized: lone error result, state untouched
      e.oversize = 1'b1;
      e.last     = 1'b1;
      planned_bursts.push_back(e);
      return;
    end
    // pending gap (non-positive balance) skips into this page
    skip    = -balance;
    wr_addr = {1'b0, addr} + WADDR_W'(skip);
    balance += int'(nbytes);
    n = 0;
    // a page that leaves the balance non-positive lies inside the gap
    while (balance > 0 && frame_on && n < BURSTS_PER_PAGE) begin
      burst = balance;
      if (burst > MAX_BURST) burst = MAX_BURST;
      if (burst > line_left) burst = line_left;
      e = '{default: '0};
      e.beat_addr = BEAT_ADDR_W'(wr_addr >> BEAT_SH);
      // under one beat still goes out, with zero beats
      e.beats     = BEATS_W'(burst >> BEAT_SH);
      line_left -= burst;
      balance   -= int'(burst);
      wr_addr    = wr_addr + WADDR_W'(burst);
      if (line_left == 0) begin
        e.line_end = 1'b1;
        if (lines_cnt < 4095) lines_cnt++;
        // count lowered mid frame: passing it also ends the frame
        if (lines_cnt >= count) begin
          e.frame_end = 1'b1;
          frame_on    = 1'b0;
        end else begin
          line_left = width;
        end
        balance -= int'(gap);
        wr_addr  = wr_addr + WADDR_W'(gap);
      end
      run.push_back(e);
      n++;
    end
    if (n > 0) run[n-1].last = 1'b1;
    foreach (run[i]) planned_bursts.push_back(run[i]);
  endtask

  // ---------------------------------------------------------------------
  // Result side: pop with random stalls, check every transfer
  // ---------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s expected %h got %h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    burst_exp_t want;
    if (!rst && pop && !empty) begin
      results_checked++;
      if (planned_bursts.size() == 0) begin
        $error("burst transfer with nothing expected: addr %h beats %0d err %b",
               burst_beat_address, burst_beats, page_error);
        mismatches++;
      end else begin
        want = planned_bursts.pop_front();
        check_field("burst_beat_address", 64'(want.beat_addr), 64'(burst_beat_address));
        check_field("burst_beats", 64'(want.beats), 64'(burst_beats));
        check_field("line_done", 64'(want.line_end), 64'(line_done));
        check_field("frame_done", 64'(want.frame_end), 64'(frame_done));
        check_field("page_error", 64'(want.oversize), 64'(page_error));
        check_field("last_of_run", 64'(want.last), 64'(last_of_run));
      end
      // stall drawn fresh after each transfer
      pop_wait = $urandom_range(0, rx_max);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_wait > 0) begin
      pop <= 1'b0;
      pop_wait--;
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bursts still expected", cycles,
               planned_bursts.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Page side and configuration; all tasks enter and leave at a falling edge
  // ---------------------------------------------------------------------
  task automatic send_page(input logic [PADDR_W-1:0] addr, input logic [PBYTES_W-1:0] nbytes,
                           input logic sof);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push           <= 1'b1;
    page_address   <= addr;
    page_bytes     <= nbytes;
    first_of_frame <= sof;
    @(posedge clk);
    while (full) @(posedge clk);
    plan_page(addr, nbytes, sof);
    pages_sent++;
    if (!page_ignored) pages_planned++;
    @(negedge clk);
  endtask

  // Sender holds off until every planned burst has been popped
  task automatic wait_results();
    push <= 1'b0;
    while (planned_bursts.size() != 0) @(negedge clk);
  endtask

  // Fully idle: also lets pages with no bursts drain from the pipeline
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Raw 16-bit writes; the block keeps the low bits of each register.
  // The spare index gets junk that must be dropped.
  task automatic set_geometry(input logic [15:0] w, input logic [15:0] s, input logic [15:0] c);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    idx = '{REG_LINE_WIDTH, REG_LINE_STRIDE, REG_LINE_COUNT, REG_SPARE};
    val = '{w, s, c, CFG_DATA_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        REG_LINE_WIDTH:  geo_width  = val[i] & 16'h3FFF;
        REG_LINE_STRIDE: geo_stride = val[i];
        REG_LINE_COUNT:  geo_count  = val[i] & 16'h0FFF;
        default: ;
      endcase
      cfg_writes++;
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PADDR_W-1:0] rand_addr();
    // now and then near the top, so the beat address loses its high bit
    if ($urandom_range(0, 7) == 0) return {36'hF_FFFF_FFFF, 12'($urandom)};
    return PADDR_W'({$urandom, $urandom});
  endfunction

  function automatic logic [PBYTES_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return PBYTES_W'($urandom_range(2048, MAX_PAGE));
    if (r < 80) return PBYTES_W'($urandom_range(1, 2047));
    if (r < 85) return MAX_PAGE;
    if (r < 88) return '0;
    if (r < 93) return PBYTES_W'($urandom_range(1, 40));
    return PBYTES_W'($urandom_range(MAX_PAGE + 1, 16383));
  endfunction

  // One frame: restart page, then pages until the frame ends or the cap hits.
  // A few pages restart mid frame; sometimes one more page trails the frame.
  task automatic run_frame(input int max_pages);
    logic sof;
    send_page(rand_addr(), rand_size(), 1'b1);
    for (int k = 1; k < max_pages && frame_on; k++) begin
      sof = ($urandom_range(0, 99) < 3);
      send_page(rand_addr(), rand_size(), sof);
    end
    if ($urandom_range(0, 3) == 0) send_page(rand_addr(), rand_size(), 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset geometry (1920/1920/1080); no frame open until a restart page
  task automatic test_inactive_and_defaults();
    settle();
    send_page(48'h0, 14'd4096, 1'b0);              // no frame yet: dropped
    send_page(48'hFFFF_FFFF_FF00, 14'd4096, 1'b1); // runs past 2^48
    send_page(48'h1234_5678_9ABC, 14'd16383, 1'b0); // all size bits set
    send_page(48'h0, 14'd8192, 1'b0);
    send_page(48'h0, MAX_PAGE + 1'b1, 1'b0);
    send_page(48'hAAAA_5555_AAAA, 14'd0, 1'b0);    // empty page
    send_page(48'h0, MAX_PAGE, 1'b0);
  endtask

  // Below-floor registers, then every register at its top value
  task automatic test_register_limits();
    settle();
    set_geometry(16'd0, 16'd0, 16'd0);
    send_page(48'h5555_AAAA_5555, MAX_PAGE, 1'b1); // one 256-byte line ends it
    send_page(48'h0, MAX_PAGE, 1'b0);              // frame done: dropped
    settle();
    set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_page(48'h0, MAX_PAGE, 1'b1);              // full-size burst
    repeat (3) send_page(rand_addr(), MAX_PAGE, 1'b0);
    send_page(rand_addr(), MAX_PAGE, 1'b0);        // lies inside the gap
  endtask

  // Odd width leaves sub-beat tails
  task automatic test_short_bursts();
    settle();
    set_geometry(16'd260, 16'd300, 16'd3);
    send_page(48'h10, 14'd250, 1'b1);
    send_page(48'h2003, 14'd5, 1'b0);              // zero-beat burst
    send_page(48'h4007, MAX_PAGE, 1'b0);
  endtask

  task automatic test_stride_below_width();
    settle();
    set_geometry(16'd1000, 16'd256, 16'd2);
    send_page(48'h8000, 14'd3000, 1'b1);
  endtask

  // Count lowered under lines already done, then restart on a bad page
  task automatic test_lowered_count();
    settle();
    set_geometry(16'd256, 16'd512, 16'd10);
    send_page(48'h0, MAX_PAGE, 1'b1);              // eight lines
    settle();
    set_geometry(16'd256, 16'd512, 16'd3);
    send_page(48'h10000, 14'd300, 1'b0);           // next line ends the frame
    settle();
    send_page(48'h20000, 14'd5000, 1'b1);          // restarts, then flagged
    send_page(48'h30000, 14'd1024, 1'b0);
  endtask

  // Random frames over eight geometries; idling varies per phase and
  // phase 6 lets every result out after each frame
  task automatic test_random_frames();
    int unsigned w, s, c;
    int          start, max_pages;
    for (int p = 0; p < 8; p++) begin
      settle();
      tx_max = (p == 2 || p == 5) ? 0 : 7;
      rx_max = (p == 3 || p == 5) ? 0 : 7;
      max_pages = 60;
      case (p)
        0: begin
          w = 256; s = 256; c = 1;
        end
        1: begin
          w = 16'hFFFF; s = 16'hFFFF; c = 2;
        end
        3: begin
          // count never reached; frames cut short
          w = $urandom_range(256, 3000); s = $urandom_range(0, w); c = 16'hFFFF;
          max_pages = 30;
        end
        4: begin
          w = $urandom_range(0, 255); s = $urandom_range(0, 255);
          c = $urandom_range(0, 15) << 12;
        end
        default: begin
          // junk in the unused high bits must be dropped
          w = $urandom_range(256, 4096) | ($urandom_range(0, 3) << 14);
          s = (w & 16'h3FFF) + $urandom_range(0, 4096);
          c = $urandom_range(1, 8) | ($urandom_range(0, 15) << 12);
        end
      endcase
      set_geometry(16'(w), 16'(s), 16'(c));
      start = pages_planned;
      while (pages_planned - start < 50) begin
        run_frame(max_pages);
        if (p == 6) wait_results();
      end
    end
    tx_max = 7;
    rx_max = 7;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_inactive_and_defaults();
    test_register_limits();
    test_short_bursts();
    test_stride_below_width();
    test_lowered_count();
    test_random_frames();
    wait_results();
    repeat (20) @(negedge clk);
    $display("Sent %0d pages (%0d planned) over 15 register settings, %0d register writes",
             pages_sent, pages_planned, cfg_writes);
    $display("Checked %0d burst/error transfers, %0d mismatches, %0d cycles",
             results_checked, mismatches, cycles);
    if (mismatches == 0 && planned_bursts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
